>>> hdl/uscj_pkg.sv
// ----------------------------------------------------------------------------
// uscj_pkg
// Shared types, constants and helpers for the unicycle knot evaluator.
// ----------------------------------------------------------------------------
package uscj_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_STEP_TIME      = 2'd0,
		REG_STATE_WEIGHT   = 2'd1,
		REG_CONTROL_WEIGHT = 2'd2
	} reg_idx_t;

	// one knot: state and controls
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] speed;
		logic signed [31:0] turn_rate;
	} knot_t;

	localparam int unsigned ATAN_ENTRIES = 30;
	localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [16:0] JAC_LIMIT = 17'd65536;
	localparam logic [39:0] COST_LIMIT = 40'hFF_FFFF_FFFF;

	// atan(2^-i) in turns, Q0.32
	function automatic logic [31:0] atan_turns(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// clamp a wide signed value to the 32 bit range
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/uscj_cordic.sv
// ----------------------------------------------------------------------------
// uscj_cordic
// Pipelined rotation CORDIC: heading reduction, quadrant fold, one stage per
// iteration, with ITERS capped at 30.
// ----------------------------------------------------------------------------
module uscj_cordic #(
	parameter int FRAC_BITS = 16,
	parameter int ITERS     = 18
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output logic signed [33:0] cos_x,
	output logic signed [33:0] sin_y,
	output logic               fold
);
	localparam int N  = (ITERS < 30) ? ITERS : 30;
	localparam int XW = 34;

	logic signed [62:0]   prod_s1;
	logic [63:0]          prod_ext;
	logic [31:0]          turn;
	logic                 fold_c;
	logic [31:0]          turn_f;
	logic signed [XW-1:0] x_s [0:N];
	logic signed [XW-1:0] y_s [0:N];
	logic signed [XW-1:0] z_s [0:N];
	logic                 fold_s [0:N];

	// angle times 1/(2*pi): turn fraction
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= angle * $signed({1'b0, uscj_pkg::INV_TWO_PI_Q32});
		end
	end

	always_comb begin
		prod_ext = {prod_s1[62], prod_s1};
		turn     = prod_ext[FRAC_BITS+31:FRAC_BITS];
		// second and third quadrant move by a half turn
		fold_c   = turn[31] ^ turn[30];
		turn_f   = fold_c ? {~turn[31], turn[30:0]} : turn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= XW'(uscj_pkg::CORDIC_GAIN_Q30);
			y_s[0]    <= '0;
			z_s[0]    <= XW'($signed(turn_f));
			fold_s[0] <= fold_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [XW-1:0] ATAN = XW'(uscj_pkg::atan_turns(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
				fold_s[i+1] <= fold_s[i];
			end
		end
	end

	assign cos_x = x_s[N];
	assign sin_y = y_s[N];
	assign fold  = fold_s[N];

endmodule

>>> hdl/uscj_cost.sv
// ----------------------------------------------------------------------------
// uscj_cost
// Quadratic cost and gradients of one knot, five pipeline stages.
// ----------------------------------------------------------------------------
module uscj_cost #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  uscj_pkg::knot_t        knot,
	input  logic [62-FRAC_BITS:0]  wx,
	input  logic [62-FRAC_BITS:0]  wu,
	output logic [39:0]            cost,
	output logic [31:0]            grad [0:4]
);
	localparam int F    = FRAC_BITS;
	localparam int W_W  = 63 - F;
	localparam int SQ_W = 63 - F;
	localparam int SX_W = SQ_W + 2;
	localparam int WL   = W_W / 2;
	localparam int WH   = W_W - WL;
	localparam int GW   = 32 + W_W;
	localparam int RW   = GW - F + 1;
	localparam int BL   = SX_W / 2;
	localparam int BH   = SX_W - BL;
	localparam int PW   = W_W + SX_W;
	localparam int TW   = PW - F;

	logic signed [31:0] v [0:4];
	logic [63:0]        sq_s1  [0:4];
	logic [31+WL:0]     glo_s1 [0:4];
	logic [31+WH:0]     ghi_s1 [0:4];
	logic               neg_s1 [0:4];
	logic [SQ_W-1:0]    sqr    [0:4];
	logic [SX_W-1:0]    sx_s2, su_s2;
	logic [31:0]        grad_s2 [0:4];
	logic [31:0]        grad_s3 [0:4];
	logic [31:0]        grad_s4 [0:4];
	logic [31:0]        grad_s5 [0:4];
	logic [WL+BL-1:0]   xp00_s3, up00_s3;
	logic [WL+BH-1:0]   xp01_s3, up01_s3;
	logic [WH+BL-1:0]   xp10_s3, up10_s3;
	logic [WH+BH-1:0]   xp11_s3, up11_s3;
	logic [PW-1:0]      px, pu;
	logic [PW:0]        rx, ru;
	logic [TW-1:0]      tx, tu;
	logic [41:0]        tx_s4, tu_s4;
	logic [42:0]        csum;
	logic [39:0]        cost_s5;

	assign v[0] = knot.pos_x;
	assign v[1] = knot.pos_y;
	assign v[2] = knot.heading;
	assign v[3] = knot.speed;
	assign v[4] = knot.turn_rate;

	for (genvar i = 0; i < 5; i++) begin : g_lane
		logic [W_W-1:0] w;
		logic [31:0]    m;
		logic [64:0]    sq_r;
		logic [GW-1:0]  g;
		logic [GW:0]    g_r;
		logic [RW-1:0]  r;
		logic [31:0]    gs;

		assign w = (i < 3) ? wx : wu;
		assign m = v[i][31] ? 32'(-v[i]) : 32'(v[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s1[i]  <= m * m;
				glo_s1[i] <= m * w[WL-1:0];
				ghi_s1[i] <= m * w[W_W-1:WL];
				neg_s1[i] <= v[i][31];
			end
		end

		always_comb begin
			sq_r   = {1'b0, sq_s1[i]} + (65'(1) << (F - 1));
			sqr[i] = sq_r[F+SQ_W-1:F];
			g      = GW'(glo_s1[i]) + (GW'(ghi_s1[i]) << WL);
			g_r    = {1'b0, g} + ((GW+1)'(1) << (F - 1));
			r      = g_r[GW:F];
			if (neg_s1[i]) begin
				gs = (r > RW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(32'd0 - r[31:0]);
			end else begin
				gs = (r > RW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[31:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				grad_s2[i] <= gs;
				grad_s3[i] <= grad_s2[i];
				grad_s4[i] <= grad_s3[i];
				grad_s5[i] <= grad_s4[i];
			end
		end

		assign grad[i] = grad_s5[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= SX_W'(sqr[0]) + SX_W'(sqr[1]) + SX_W'(sqr[2]);
			su_s2 <= SX_W'(sqr[3]) + SX_W'(sqr[4]);
		end
	end

	// weight times squared norm as four partial products
	always_ff @(posedge clk) begin
		if (en) begin
			xp00_s3 <= wx[WL-1:0]   * sx_s2[BL-1:0];
			xp01_s3 <= wx[WL-1:0]   * sx_s2[SX_W-1:BL];
			xp10_s3 <= wx[W_W-1:WL] * sx_s2[BL-1:0];
			xp11_s3 <= wx[W_W-1:WL] * sx_s2[SX_W-1:BL];
			up00_s3 <= wu[WL-1:0]   * su_s2[BL-1:0];
			up01_s3 <= wu[WL-1:0]   * su_s2[SX_W-1:BL];
			up10_s3 <= wu[W_W-1:WL] * su_s2[BL-1:0];
			up11_s3 <= wu[W_W-1:WL] * su_s2[SX_W-1:BL];
		end
	end

	always_comb begin
		px = PW'(xp00_s3) + (PW'(xp01_s3) << BL) + (PW'(xp10_s3) << WL)
			+ (PW'(xp11_s3) << (WL + BL));
		pu = PW'(up00_s3) + (PW'(up01_s3) << BL) + (PW'(up10_s3) << WL)
			+ (PW'(up11_s3) << (WL + BL));
		// round with the extra halving shift
		rx = {1'b0, px} + ((PW+1)'(1) << F);
		ru = {1'b0, pu} + ((PW+1)'(1) << F);
		tx = rx[PW:F+1];
		tu = ru[PW:F+1];
	end

	// anything at or above 2^41 saturates the cost anyway
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4 <= (|tx[TW-1:41]) ? (42'(1) << 41) : tx[41:0];
			tu_s4 <= (|tu[TW-1:41]) ? (42'(1) << 41) : tu[41:0];
		end
	end

	assign csum = {1'b0, tx_s4} + {1'b0, tu_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			cost_s5 <= (csum > 43'(uscj_pkg::COST_LIMIT)) ? uscj_pkg::COST_LIMIT : csum[39:0];
		end
	end

	assign cost = cost_s5;

endmodule

>>> hdl/unicycle_step_cost_jacobian.sv
// ----------------------------------------------------------------------------
// unicycle_step_cost_jacobian
// Unicycle knot evaluator: Euler step, quadratic cost, gradients and the
// cos*dt / sin*dt Jacobian terms, one knot per clock unless out_stall holds a result.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     pos_x pos_y heading speed turn_rate
//  out      out_valid / out_stall   next_pos_* next_heading cost grad_* cos_dt sin_dt
//  cfg      cfg_wr_en               cfg_index cfg_data
//
//  the path is one CORDIC stage per iteration (capped at 30) plus reduction
//  and the multiply/round tail; one item a cycle unless a stalled result holds it.
//  arst_n clears the valid bits and the registers to dt 0.1, ws 10, wc 1.
//  a stalled result at the output freezes the whole pipeline; in_stall
//  follows out_stall only while the last stage holds an item.
// ----------------------------------------------------------------------------
module unicycle_step_cost_jacobian #(
	parameter int FRAC_BITS         = 16,
	parameter int CORDIC_ITERATIONS = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] heading,
	input  logic signed [31:0] speed,
	input  logic signed [31:0] turn_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] next_pos_x,
	output logic signed [31:0] next_pos_y,
	output logic signed [31:0] next_heading,
	output logic [39:0]        cost,
	output logic signed [31:0] grad_pos_x,
	output logic signed [31:0] grad_pos_y,
	output logic signed [31:0] grad_heading,
	output logic signed [31:0] grad_speed,
	output logic signed [31:0] grad_turn_rate,
	output logic signed [17:0] cos_dt,
	output logic signed [17:0] sin_dt
);
	localparam int F    = FRAC_BITS;
	localparam int N    = (CORDIC_ITERATIONS < 30) ? CORDIC_ITERATIONS : 30;
	localparam int D    = N + 2;
	localparam int LAT  = D + 5;
	localparam int W_W  = 63 - F;
	localparam int HDW  = 50 - F;
	localparam logic [16:0] STEP_RST = 17'(((1 << F) + 5) / 10);
	localparam logic [31:0] SW_RST   = 32'(10 << F);
	localparam logic [31:0] CW_RST   = 32'(1 << F);

	logic [16:0]      step_time_q;
	logic [31:0]      state_weight_q, control_weight_q;
	logic [31:0]      swm, cwm;
	logic [64:0]      wx_r, wu_r;
	logic [W_W-1:0]   wx_q, wu_q;
	logic             en;
	logic             vld_q [1:LAT];
	uscj_pkg::knot_t  dly_s [1:D];
	uscj_pkg::knot_t  knot_in;
	logic signed [33:0] cx, sy;
	logic             cfold;
	logic [39:0]      cost_w;
	logic [31:0]      grad_w [0:4];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q      <= STEP_RST;
			state_weight_q   <= SW_RST;
			control_weight_q <= CW_RST;
		end else if (cfg_wr_en) begin
			unique case (uscj_pkg::reg_idx_t'(cfg_index))
				uscj_pkg::REG_STEP_TIME:      step_time_q      <= cfg_data[16:0];
				uscj_pkg::REG_STATE_WEIGHT:   state_weight_q   <= cfg_data;
				uscj_pkg::REG_CONTROL_WEIGHT: control_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// squared weights, rounded to the fixed point grid
	always_comb begin
		swm  = state_weight_q[31] ? 32'(-state_weight_q) : state_weight_q;
		cwm  = control_weight_q[31] ? 32'(-control_weight_q) : control_weight_q;
		wx_r = 65'(swm * swm) + (65'(1) << (F - 1));
		wu_r = 65'(cwm * cwm) + (65'(1) << (F - 1));
	end

	always_ff @(posedge clk) begin
		wx_q <= wx_r[F+W_W-1:F];
		wu_q <= wu_r[F+W_W-1:F];
	end

	// pipeline advance
	assign en        = !(vld_q[LAT] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= in_valid;
			for (int k = 2; k <= LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	assign knot_in = '{pos_x: pos_x, pos_y: pos_y, heading: heading,
		speed: speed, turn_rate: turn_rate};

	// knot travels alongside the CORDIC
	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[1] <= knot_in;
			for (int k = 2; k <= D; k++) dly_s[k] <= dly_s[k-1];
		end
	end

	uscj_cordic #(
		.FRAC_BITS (F),
		.ITERS     (N)
	) u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (heading),
		.cos_x (cx),
		.sin_y (sy),
		.fold  (cfold)
	);

	uscj_cost #(
		.FRAC_BITS (F)
	) u_cost (
		.clk  (clk),
		.en   (en),
		.knot (dly_s[D]),
		.wx   (wx_q),
		.wu   (wu_q),
		.cost (cost_w),
		.grad (grad_w)
	);

	// ---------------- kinematic tail ----------------
	logic [33:0]      cm, sm;
	logic [31:0]      hm;
	logic [49:0]      pc_s1, ps_s1;
	logic [48:0]      ph_s1;
	logic             cneg_s1, sneg_s1, hneg_s1;
	uscj_pkg::knot_t  k_s1, k_s2, k_s3, k_s4;
	logic [50:0]      rc, rs;
	logic [20:0]      rcm, rsm;
	logic [49:0]      rh;
	logic [16:0]      cdm_s2, sdm_s2;
	logic             cneg_s2, sneg_s2, hneg_s2;
	logic [HDW-1:0]   hdm_s2;
	logic [31:0]      spm;
	logic [48:0]      pxp_s3, pyp_s3;
	logic             xneg_s3, yneg_s3;
	logic [31:0]      nh_s3, nh_s4, nh_s5;
	logic [17:0]      cdt_s2, sdt_s2, cdt_s3, sdt_s3, cdt_s4, sdt_s4, cdt_s5, sdt_s5;
	logic [49:0]      rx, ry;
	logic [HDW-1:0]   dxm_s4, dym_s4;
	logic             xneg_s4, yneg_s4;
	logic [31:0]      nx_s5, ny_s5;

	always_comb begin
		cm = cx[33] ? 34'(-cx) : 34'(cx);
		sm = sy[33] ? 34'(-sy) : 34'(sy);
		hm = dly_s[D].turn_rate[31] ? 32'(-dly_s[D].turn_rate) : 32'(dly_s[D].turn_rate);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1   <= cm[32:0] * step_time_q;
			ps_s1   <= sm[32:0] * step_time_q;
			ph_s1   <= hm * step_time_q;
			cneg_s1 <= cx[33] ^ cfold;
			sneg_s1 <= sy[33] ^ cfold;
			hneg_s1 <= dly_s[D].turn_rate[31];
			k_s1    <= dly_s[D];
		end
	end

	always_comb begin
		rc  = {1'b0, pc_s1} + (51'(1) << 29);
		rs  = {1'b0, ps_s1} + (51'(1) << 29);
		rcm = rc[50:30];
		rsm = rs[50:30];
		rh  = {1'b0, ph_s1} + (50'(1) << (F - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cdm_s2  <= (rcm > 21'(uscj_pkg::JAC_LIMIT)) ? uscj_pkg::JAC_LIMIT : rcm[16:0];
			sdm_s2  <= (rsm > 21'(uscj_pkg::JAC_LIMIT)) ? uscj_pkg::JAC_LIMIT : rsm[16:0];
			cneg_s2 <= cneg_s1;
			sneg_s2 <= sneg_s1;
			hdm_s2  <= rh[49:F];
			hneg_s2 <= hneg_s1;
			k_s2    <= k_s1;
		end
	end

	always_comb begin
		cdt_s2 = cneg_s2 ? 18'(-{1'b0, cdm_s2}) : {1'b0, cdm_s2};
		sdt_s2 = sneg_s2 ? 18'(-{1'b0, sdm_s2}) : {1'b0, sdm_s2};
		spm    = k_s2.speed[31] ? 32'(-k_s2.speed) : 32'(k_s2.speed);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxp_s3  <= cdm_s2 * spm;
			pyp_s3  <= sdm_s2 * spm;
			xneg_s3 <= cneg_s2 ^ k_s2.speed[31];
			yneg_s3 <= sneg_s2 ^ k_s2.speed[31];
			nh_s3   <= uscj_pkg::sat32(64'(k_s2.heading)
				+ (hneg_s2 ? -64'(hdm_s2) : 64'(hdm_s2)));
			cdt_s3  <= cdt_s2;
			sdt_s3  <= sdt_s2;
			k_s3    <= k_s2;
		end
	end

	always_comb begin
		rx = {1'b0, pxp_s3} + (50'(1) << (F - 1));
		ry = {1'b0, pyp_s3} + (50'(1) << (F - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxm_s4  <= rx[49:F];
			dym_s4  <= ry[49:F];
			xneg_s4 <= xneg_s3;
			yneg_s4 <= yneg_s3;
			nh_s4   <= nh_s3;
			cdt_s4  <= cdt_s3;
			sdt_s4  <= sdt_s3;
			k_s4    <= k_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5  <= uscj_pkg::sat32(64'(k_s4.pos_x)
				+ (xneg_s4 ? -64'(dxm_s4) : 64'(dxm_s4)));
			ny_s5  <= uscj_pkg::sat32(64'(k_s4.pos_y)
				+ (yneg_s4 ? -64'(dym_s4) : 64'(dym_s4)));
			nh_s5  <= nh_s4;
			cdt_s5 <= cdt_s4;
			sdt_s5 <= sdt_s4;
		end
	end

	assign next_pos_x     = nx_s5;
	assign next_pos_y     = ny_s5;
	assign next_heading   = nh_s5;
	assign cos_dt         = cdt_s5;
	assign sin_dt         = sdt_s5;
	assign cost           = cost_w;
	assign grad_pos_x     = grad_w[0];
	assign grad_pos_y     = grad_w[1];
	assign grad_heading   = grad_w[2];
	assign grad_speed     = grad_w[3];
	assign grad_turn_rate = grad_w[4];

endmodule

>>> dv/unicycle_step_cost_jacobian_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicycle_step_cost_jacobian_tb
// Streams unicycle knots through the evaluator under random input gaps and
// output stalls, predicts every result field in fixed point and checks them
// in order. Step time and both weights are swept between phases.
// ----------------------------------------------------------------------------

typedef struct {
	logic [31:0] nx, ny, nh;
	logic [39:0] cost;
	logic [31:0] gx, gy, gh, gv, gw;
	logic [17:0] cdt, sdt;
} knot_result_t;

class knot_scoreboard;
	knot_result_t pending[$];
	int errors;
	int checked;
	logic [16:0] dt;
	logic [31:0] ws, wc;

	function new();
		errors = 0;
		checked = 0;
		dt = 17'd6554;
		ws = 32'd655360;
		wc = 32'd65536;
	endfunction

	static function logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// rounded a*b >> s, ties away from zero, saturated at 2^64-1
	static function logic [63:0] umul_round(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [128:0] p;
		p = a * b;
		p = p + (129'd1 << (s - 1));
		p = p >> s;
		if (p[128:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
		return p[63:0];
	endfunction

	static function logic signed [63:0] smul_round(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic [63:0] r;
		r = umul_round(magnitude(a), magnitude(b), s);
		if (r > 64'h4000_0000_0000_0000) r = 64'h4000_0000_0000_0000;
		return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
	endfunction

	static function logic signed [63:0] clamp_jac(input logic signed [63:0] v);
		if (v > 64'sd65536) return 64'sd65536;
		if (v < -64'sd65536) return -64'sd65536;
		return v;
	endfunction

	static function logic [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// rotation-mode cordic over turns, Q2.30 outputs
	static function void rotate(input logic signed [31:0] ang,
			output logic signed [63:0] c, output logic signed [63:0] s);
		logic [63:0] prod;
		logic [31:0] p;
		logic fold;
		logic signed [63:0] x, y, z, dx, dy;
		logic [31:0] at;
		prod = {{32{ang[31]}}, ang} * 64'd683565276;
		p = prod[47:16];
		fold = (p + 32'h4000_0000) >> 31;
		x = 64'sd652032874;
		y = 0;
		if (fold) p = p ^ 32'h8000_0000;
		z = {{32{p[31]}}, p};
		for (int i = 0; i < 18; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			at = uscj_pkg::atan_turns(i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - at;
			end else begin
				x = x + dx; y = y - dy; z = z + at;
			end
		end
		c = fold ? -x : x;
		s = fold ? -y : y;
	endfunction

	function void note_knot(input uscj_pkg::knot_t k);
		knot_result_t r;
		logic signed [63:0] v[5];
		logic signed [63:0] c, s, cd, sd;
		logic [63:0] wx, wu, sqx, squ, a, b, sum;
		v[0] = k.pos_x; v[1] = k.pos_y; v[2] = k.heading;
		v[3] = k.speed; v[4] = k.turn_rate;
		rotate(k.heading, c, s);
		cd = clamp_jac(smul_round(c, {47'd0, dt}, 30));
		sd = clamp_jac(smul_round(s, {47'd0, dt}, 30));
		r.nx = clamp32(v[0] + smul_round(cd, v[3], 16));
		r.ny = clamp32(v[1] + smul_round(sd, v[3], 16));
		r.nh = clamp32(v[2] + smul_round(v[4], {47'd0, dt}, 16));
		wx = umul_round(magnitude($signed(ws)), magnitude($signed(ws)), 16);
		wu = umul_round(magnitude($signed(wc)), magnitude($signed(wc)), 16);
		sqx = 0; squ = 0;
		for (int i = 0; i < 3; i++) sqx += umul_round(magnitude(v[i]), magnitude(v[i]), 16);
		for (int i = 3; i < 5; i++) squ += umul_round(magnitude(v[i]), magnitude(v[i]), 16);
		a = umul_round(wx, sqx, 17);
		b = umul_round(wu, squ, 17);
		sum = a + b;
		if (sum < a) sum = 64'hFFFF_FFFF_FFFF_FFFF;
		r.cost = sum > 64'hFF_FFFF_FFFF ? uscj_pkg::COST_LIMIT : sum[39:0];
		if (wx > 64'h4000_0000_0000_0000) wx = 64'h4000_0000_0000_0000;
		if (wu > 64'h4000_0000_0000_0000) wu = 64'h4000_0000_0000_0000;
		r.gx = clamp32(smul_round(wx, v[0], 16));
		r.gy = clamp32(smul_round(wx, v[1], 16));
		r.gh = clamp32(smul_round(wx, v[2], 16));
		r.gv = clamp32(smul_round(wu, v[3], 16));
		r.gw = clamp32(smul_round(wu, v[4], 16));
		r.cdt = cd[17:0];
		r.sdt = sd[17:0];
		pending.push_back(r);
	endfunction

	function void compare(input string name, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
		end
	endfunction

	function void check_result(input knot_result_t got);
		knot_result_t e;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t unexpected result item", $time);
			return;
		end
		e = pending.pop_front();
		checked++;
		compare("next_pos_x", e.nx, got.nx);
		compare("next_pos_y", e.ny, got.ny);
		compare("next_heading", e.nh, got.nh);
		compare("cost", e.cost, got.cost);
		compare("grad_pos_x", e.gx, got.gx);
		compare("grad_pos_y", e.gy, got.gy);
		compare("grad_heading", e.gh, got.gh);
		compare("grad_speed", e.gv, got.gv);
		compare("grad_turn_rate", e.gw, got.gw);
		compare("cos_dt", e.cdt, got.cdt);
		compare("sin_dt", e.sdt, got.sdt);
	endfunction
endclass

module unicycle_step_cost_jacobian_tb;
	localparam int LATENCY = 25;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0] pos_x, pos_y, heading, speed, turn_rate;
	logic signed [31:0] next_pos_x, next_pos_y, next_heading;
	logic [39:0] cost;
	logic signed [31:0] grad_pos_x, grad_pos_y, grad_heading, grad_speed, grad_turn_rate;
	logic signed [17:0] cos_dt, sin_dt;

	knot_scoreboard sb;
	int gap_pct;
	int stall_pct;
	longint cycles;
	int sent;

	unicycle_step_cost_jacobian dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("unicycle_step_cost_jacobian regression: fail");
				$finish;
			end
		end
	end

	// output side: random stall, check accepted results
	always @(posedge clk or negedge arst_n) begin
		knot_result_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.nx = next_pos_x; got.ny = next_pos_y; got.nh = next_heading;
				got.cost = cost;
				got.gx = grad_pos_x; got.gy = grad_pos_y; got.gh = grad_heading;
				got.gv = grad_speed; got.gw = grad_turn_rate;
				got.cdt = cos_dt; got.sdt = sin_dt;
				sb.check_result(got);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// the caller drops cfg_wr_en after its last write
	task automatic write_reg(input uscj_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			uscj_pkg::REG_STEP_TIME: sb.dt = val[16:0];
			uscj_pkg::REG_STATE_WEIGHT: sb.ws = val;
			uscj_pkg::REG_CONTROL_WEIGHT: sb.wc = val;
			default: ;
		endcase
	endtask

	// drive one knot, hold until accepted; in_valid stays up for the next one
	task automatic send_knot(input uscj_pkg::knot_t k);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= k.pos_x; pos_y <= k.pos_y; heading <= k.heading;
		speed <= k.speed; turn_rate <= k.turn_rate;
		do @(posedge clk); while (in_stall);
		sb.note_knot(k);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(131072)) - 65536;
			2: return $signed($urandom_range(2097152)) - 1048576;
			3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
			default: return $signed($urandom_range(1310720)) - 655360;
		endcase
	endfunction

	function automatic uscj_pkg::knot_t rand_knot();
		uscj_pkg::knot_t k;
		k.pos_x = rand_word(); k.pos_y = rand_word(); k.heading = rand_word();
		k.speed = rand_word(); k.turn_rate = rand_word();
		return k;
	endfunction

	initial begin
		uscj_pkg::knot_t k;
		logic [31:0] corner[8];
		logic [31:0] dts[4];
		logic [31:0] wts[5];
		sb = new();
		sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 0;
		cfg_wr_en = 0; cfg_index = uscj_pkg::REG_STEP_TIME; cfg_data = 0;
		in_valid = 0;
		pos_x = 0; pos_y = 0; heading = 0; speed = 0; turn_rate = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, quarter turns, wrap, zero
		corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd102944, -32'sd102944, 32'd205887};
		for (int i = 0; i < 8; i++) begin
			k.pos_x = corner[i]; k.pos_y = corner[7 - i]; k.heading = corner[i];
			k.speed = corner[(i + 3) % 8]; k.turn_rate = corner[(i + 5) % 8];
			send_knot(k);
		end
		for (int i = 0; i < 8; i++) begin
			k = '{default: 0};
			k.heading = i * 51472;
			k.speed = 32'h7FFF_FFFF;
			k.turn_rate = 32'h8000_0000;
			send_knot(k);
		end
		drain();

		dts = '{32'd0, 32'd65536, 32'h1FFFF, 32'd6554};
		wts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, -32'sd65536, 32'd655360};
		for (int ph = 0; ph < 9; ph++) begin
			write_reg(uscj_pkg::REG_STEP_TIME, ph < 4 ? dts[ph] : $urandom_range(131071));
			write_reg(uscj_pkg::REG_STATE_WEIGHT, ph < 5 ? wts[ph] : rand_word());
			write_reg(uscj_pkg::REG_CONTROL_WEIGHT, ph < 5 ? wts[4 - ph] : rand_word());
			cfg_wr_en <= 1'b0;
			for (int n = 0; n < 150; n++) begin
				// first phase runs back to back with no gaps or stalls
				gap_pct = (ph == 0) ? 0 : 33;
				stall_pct = (ph == 0) ? 0 : 33;
				send_knot(rand_knot());
			end
			drain();
		end

		stall_pct = 0;
		drain();
		$display("sent %0d knots, checked %0d results over 10 register settings",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("unicycle_step_cost_jacobian regression: pass");
		end else begin
			$display("unicycle_step_cost_jacobian regression: fail");
		end
		$finish;
	end
endmodule
